// ===== rtl/hcb_pkg.sv =====
// hcb_pkg: shared types and constants for the huffman code builder
// no dependencies; used by every module of the block
package hcb_pkg;

  // fixed widths of the port fields
  localparam int unsigned IN_WEIGHT_BITS = 16;
  localparam int unsigned OUT_SYM_BITS   = 4;
  localparam int unsigned OUT_LEN_BITS   = 4;
  localparam int unsigned OUT_CODE_BITS  = 15;

  // depth of the queue between front and engine
  localparam int unsigned QUEUE_DEPTH = 2;

  // queue status seen by producer and consumer
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // engine sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PU_CHK,
    ST_PU_CMP,
    ST_BLD_CHK,
    ST_POP_RD,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_SD_L,
    ST_SD_LW,
    ST_SD_RW,
    ST_SD_DEC,
    ST_LINK0,
    ST_LINK1,
    ST_WK_CHK,
    ST_WK_STEP,
    ST_EMIT
  } hcb_state_e;

endpackage

// ===== rtl/hcb_front.sv =====
// hcb_front: takes input beats, trims weights and marks the beat that closes a set
// depends on hcb_pkg; feeds hcb_queue
module hcb_front #(
  parameter int unsigned SYMBOLS     = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [hcb_pkg::IN_WEIGHT_BITS-1:0]   weight_i,
  input  logic                                 last_weight_i,
  input  hcb_pkg::q_stat_t                     q_stat_i,
  input  logic                                 done_i,
  output logic                                 busy_o,
  output logic                                 push_o,
  output logic [WEIGHT_BITS:0]                 push_data_o
);

  localparam int unsigned CW = $clog2(SYMBOLS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          closed_q, closed_d;
  logic          close_beat;
  logic [31:0]   w_ext;

  // accept while no set is waiting to be built and the queue has room
  assign busy_o = closed_q | q_stat_i.full;
  assign push_o = start_i & ~busy_o;

  // weight cut to the configured width
  assign w_ext       = 32'(weight_i);
  assign close_beat  = last_weight_i | (cnt_q == CW'(SYMBOLS - 1));
  assign push_data_o = {close_beat, w_ext[WEIGHT_BITS-1:0]};

  // symbol count and closed flag
  always_comb begin
    cnt_d    = cnt_q;
    closed_d = closed_q;
    if (done_i) begin
      closed_d = 1'b0;
    end
    if (push_o) begin
      if (close_beat) begin
        cnt_d    = '0;
        closed_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      closed_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      closed_q <= closed_d;
    end
  end

endmodule

// ===== rtl/hcb_queue.sv =====
// hcb_queue: short fifo between the front and the engine
// depends on hcb_pkg
module hcb_queue #(
  parameter int unsigned DW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DW-1:0]    push_data_i,
  input  logic             pop_i,
  output logic [DW-1:0]    pop_data_o,
  output hcb_pkg::q_stat_t stat_o
);

  localparam int unsigned PW = $clog2(hcb_pkg::QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(hcb_pkg::QUEUE_DEPTH + 1);

  logic [DW-1:0] slot_q [hcb_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [FW-1:0] fill_q;

  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (fill_q == FW'(hcb_pkg::QUEUE_DEPTH));
  assign pop_data_o   = slot_q[rd_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FW'(1);
      end
    end
  end

endmodule

// ===== rtl/hcb_engine.sv =====
// hcb_engine: heap insert, merge loop and code walk over two small memories
// depends on hcb_pkg; drains hcb_queue
module hcb_engine #(
  parameter int unsigned SYMBOLS     = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hcb_pkg::q_stat_t                    q_stat_i,
  input  logic [WEIGHT_BITS:0]                q_data_i,
  output logic                                q_pop_o,
  output logic                                done_o,
  output logic                                valid_o,
  output logic [hcb_pkg::OUT_SYM_BITS-1:0]    symbol_o,
  output logic [hcb_pkg::OUT_LEN_BITS-1:0]    code_length_o,
  output logic [hcb_pkg::OUT_CODE_BITS-1:0]   code_bits_o,
  output logic                                last_code_o
);

  localparam int unsigned CW    = $clog2(SYMBOLS + 1);
  localparam int unsigned HAW   = $clog2(SYMBOLS);
  localparam int unsigned NB    = $clog2(2 * SYMBOLS);
  localparam int unsigned SW    = WEIGHT_BITS + $clog2(SYMBOLS);
  localparam int unsigned EW    = SW + NB;
  localparam int unsigned LW    = $clog2(SYMBOLS + 1);
  localparam int unsigned NODES = 2 * SYMBOLS;
  localparam int unsigned CB    = hcb_pkg::OUT_CODE_BITS;

  hcb_pkg::hcb_state_e state_q, state_d;

  // heap and link memories
  logic [EW-1:0] hmem [SYMBOLS];
  logic [NB:0]   lmem [NODES];

  logic          h_we;
  logic [HAW-1:0] h_wa, h_ra;
  logic [EW-1:0] h_wd, rd_q;
  logic          l_we;
  logic [NB-1:0] l_wa, l_ra;
  logic [NB:0]   l_wd, lrd_q;

  logic [CW-1:0]  cnt_q, cnt_d, n_q, n_d, s_q, s_d;
  logic [NB-1:0]  next_q, next_d, cur_q, cur_d, node_q, node_d;
  logic [SW-1:0]  w_q, w_d;
  logic [HAW-1:0] i_q, i_d, bidx_q, bidx_d;
  logic [EW-1:0]  best_q, best_d, a_q, a_d, b_q, b_d;
  logic           bx_q, bx_d, close_q, close_d, bld_q, bld_d, sec_q, sec_d;
  logic [LW-1:0]  len_q, len_d;
  logic [CB-1:0]  code_q, code_d;

  logic [31:0]    l_ext, r_ext, c_ext, s_ext, len_ext;
  logic [HAW-1:0] par;
  logic [EW-1:0]  x_ent;
  logic [NB:0]    root;
  logic           l_ok, r_ok, at_root, last_sym;

  // heap index arithmetic
  assign l_ext   = 32'({i_q, 1'b1});
  assign r_ext   = l_ext + 32'd1;
  assign c_ext   = 32'(cnt_q);
  assign l_ok    = l_ext < c_ext;
  assign r_ok    = r_ext < c_ext;
  assign par     = (i_q - HAW'(1)) >> 1;
  assign x_ent   = {w_q, node_q};
  assign root    = (NB + 1)'({n_q, 1'b0}) - (NB + 1)'(2);
  assign at_root = ({1'b0, cur_q} == root) || (len_q == LW'(SYMBOLS));
  assign last_sym = ((s_q + CW'(1)) == n_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hcb_pkg::ST_IDLE:     if (!q_stat_i.empty) state_d = hcb_pkg::ST_PU_CHK;
      hcb_pkg::ST_PU_CHK: begin
        if (i_q == '0) begin
          state_d = (close_q || bld_q) ? hcb_pkg::ST_BLD_CHK : hcb_pkg::ST_IDLE;
        end else begin
          state_d = hcb_pkg::ST_PU_CMP;
        end
      end
      hcb_pkg::ST_PU_CMP: begin
        if (rd_q[EW-1:NB] > w_q) begin
          state_d = hcb_pkg::ST_PU_CHK;
        end else begin
          state_d = (close_q || bld_q) ? hcb_pkg::ST_BLD_CHK : hcb_pkg::ST_IDLE;
        end
      end
      hcb_pkg::ST_BLD_CHK:  state_d = (cnt_q > CW'(1)) ? hcb_pkg::ST_POP_RD
                                                      : hcb_pkg::ST_WK_CHK;
      hcb_pkg::ST_POP_RD:   state_d = hcb_pkg::ST_POP_ROOT;
      hcb_pkg::ST_POP_ROOT: state_d = hcb_pkg::ST_POP_LAST;
      hcb_pkg::ST_POP_LAST: state_d = hcb_pkg::ST_SD_L;
      hcb_pkg::ST_SD_L: begin
        if (l_ok) begin
          state_d = hcb_pkg::ST_SD_LW;
        end else begin
          state_d = sec_q ? hcb_pkg::ST_LINK0 : hcb_pkg::ST_POP_RD;
        end
      end
      hcb_pkg::ST_SD_LW:    state_d = r_ok ? hcb_pkg::ST_SD_RW : hcb_pkg::ST_SD_DEC;
      hcb_pkg::ST_SD_RW:    state_d = hcb_pkg::ST_SD_DEC;
      hcb_pkg::ST_SD_DEC: begin
        if (bx_q) begin
          state_d = sec_q ? hcb_pkg::ST_LINK0 : hcb_pkg::ST_POP_RD;
        end else begin
          state_d = hcb_pkg::ST_SD_L;
        end
      end
      hcb_pkg::ST_LINK0:    state_d = hcb_pkg::ST_LINK1;
      hcb_pkg::ST_LINK1:    state_d = hcb_pkg::ST_PU_CHK;
      hcb_pkg::ST_WK_CHK: begin
        if (n_q == CW'(1) || at_root) begin
          state_d = hcb_pkg::ST_EMIT;
        end else begin
          state_d = hcb_pkg::ST_WK_STEP;
        end
      end
      hcb_pkg::ST_WK_STEP:  state_d = hcb_pkg::ST_WK_CHK;
      hcb_pkg::ST_EMIT:     state_d = last_sym ? hcb_pkg::ST_IDLE : hcb_pkg::ST_WK_CHK;
      default:              state_d = hcb_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d = cnt_q;   n_d = n_q;       s_d = s_q;
    next_d = next_q; cur_d = cur_q;   node_d = node_q;
    w_d = w_q;       i_d = i_q;       bidx_d = bidx_q;
    best_d = best_q; a_d = a_q;       b_d = b_q;
    bx_d = bx_q;     close_d = close_q; bld_d = bld_q; sec_d = sec_q;
    len_d = len_q;   code_d = code_q;
    h_we = 1'b0; h_wa = i_q; h_wd = x_ent; h_ra = '0;
    l_we = 1'b0; l_wa = a_q[NB-1:0]; l_wd = {next_q, 1'b0}; l_ra = cur_q;
    q_pop_o = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      // take one weight from the queue and start its insert
      hcb_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          w_d     = SW'(q_data_i[WEIGHT_BITS-1:0]);
          node_d  = NB'(n_q);
          n_d     = n_q + CW'(1);
          i_d     = HAW'(cnt_q);
          cnt_d   = cnt_q + CW'(1);
          close_d = q_data_i[WEIGHT_BITS];
        end
      end
      // sift up: settle at root, or fetch parent and move it down or settle
      hcb_pkg::ST_PU_CHK: begin
        if (i_q == '0) begin
          h_we = 1'b1;
        end else begin
          h_ra = par;
        end
      end
      hcb_pkg::ST_PU_CMP: begin
        h_we = 1'b1;
        if (rd_q[EW-1:NB] > w_q) begin
          h_wd = rd_q;
          i_d  = par;
        end
      end
      // start merge loop or the code walk
      hcb_pkg::ST_BLD_CHK: begin
        bld_d = 1'b1;
        sec_d = 1'b0;
        // first parent index follows the leaves
        if (!bld_q) begin
          next_d = NB'(n_q);
        end
        if (cnt_q == '0 || cnt_q == CW'(1)) begin
          s_d    = '0;
          cur_d  = '0;
          len_d  = '0;
          code_d = '0;
        end
      end
      // pop: read root, then last entry
      hcb_pkg::ST_POP_RD: h_ra = '0;
      hcb_pkg::ST_POP_ROOT: begin
        if (sec_q) begin
          b_d = rd_q;
        end else begin
          a_d = rd_q;
        end
        cnt_d = cnt_q - CW'(1);
        h_ra  = HAW'(cnt_q - CW'(1));
      end
      hcb_pkg::ST_POP_LAST: begin
        w_d    = rd_q[EW-1:NB];
        node_d = rd_q[NB-1:0];
        i_d    = '0;
      end
      // sift down: left child, right child, then move
      hcb_pkg::ST_SD_L: begin
        if (l_ok) begin
          h_ra = l_ext[HAW-1:0];
        end else begin
          h_we  = 1'b1;
          sec_d = 1'b1;
        end
      end
      hcb_pkg::ST_SD_LW: begin
        if (rd_q[EW-1:NB] < w_q) begin
          best_d = rd_q;
          bidx_d = l_ext[HAW-1:0];
          bx_d   = 1'b0;
        end else begin
          best_d = x_ent;
          bx_d   = 1'b1;
        end
        if (r_ok) begin
          h_ra = r_ext[HAW-1:0];
        end
      end
      hcb_pkg::ST_SD_RW: begin
        if (rd_q[EW-1:NB] < best_q[EW-1:NB]) begin
          best_d = rd_q;
          bidx_d = r_ext[HAW-1:0];
          bx_d   = 1'b0;
        end
      end
      hcb_pkg::ST_SD_DEC: begin
        h_we = 1'b1;
        if (bx_q) begin
          sec_d = 1'b1;
        end else begin
          h_wd = best_q;
          i_d  = bidx_q;
        end
      end
      // link both children to the new parent, then insert it
      hcb_pkg::ST_LINK0: l_we = 1'b1;
      hcb_pkg::ST_LINK1: begin
        l_we   = 1'b1;
        l_wa   = b_q[NB-1:0];
        l_wd   = {next_q, 1'b1};
        w_d    = a_q[EW-1:NB] + b_q[EW-1:NB];
        node_d = next_q;
        next_d = next_q + NB'(1);
        i_d    = HAW'(cnt_q);
        cnt_d  = cnt_q + CW'(1);
        sec_d  = 1'b0;
      end
      // code walk, one link per step
      hcb_pkg::ST_WK_CHK: begin
        if (n_q == CW'(1)) begin
          len_d = LW'(1);
        end
      end
      hcb_pkg::ST_WK_STEP: begin
        code_d = code_q | (CB'(lrd_q[0]) << len_q);
        len_d  = len_q + LW'(1);
        cur_d  = lrd_q[NB:1];
      end
      hcb_pkg::ST_EMIT: begin
        if (last_sym) begin
          done_o  = 1'b1;
          cnt_d   = '0;
          n_d     = '0;
          close_d = 1'b0;
          bld_d   = 1'b0;
        end else begin
          s_d    = s_q + CW'(1);
          cur_d  = NB'(s_q + CW'(1));
          len_d  = '0;
          code_d = '0;
        end
      end
      default: ;
    endcase
  end

  // result beat
  assign s_ext         = 32'(s_q);
  assign len_ext       = 32'(len_q);
  assign valid_o       = (state_q == hcb_pkg::ST_EMIT);
  assign symbol_o      = s_ext[hcb_pkg::OUT_SYM_BITS-1:0];
  assign code_length_o = len_ext[hcb_pkg::OUT_LEN_BITS-1:0];
  assign code_bits_o   = code_q;
  assign last_code_o   = last_sym;

  // memories
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    rd_q <= hmem[h_ra];
    if (l_we) begin
      lmem[l_wa] <= l_wd;
    end
    lrd_q <= lmem[l_ra];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_q <= s_d;       next_q <= next_d; cur_q <= cur_d;   node_q <= node_d;
    w_q <= w_d;       i_q <= i_d;       bidx_q <= bidx_d; best_q <= best_d;
    a_q <= a_d;       b_q <= b_d;       bx_q <= bx_d;     sec_q <= sec_d;
    len_q <= len_d;   code_q <= code_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcb_pkg::ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      close_q <= 1'b0;
      bld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      close_q <= close_d;
      bld_q   <= bld_d;
    end
  end

endmodule

// ===== rtl/huffman_code_builder.sv =====
// huffman_code_builder: top level, front, queue and heap engine
// depends on hcb_pkg, hcb_front, hcb_queue, hcb_engine
//
// usage: drive weight_i/last_weight_i with start_i; a beat is taken at an edge
// where start_i is high and busy_o is low. last_weight_i, or the SYMBOLS-th
// weight, closes the set. busy_o stays high from the closing beat until the
// last code of that set has left, and also while the two-entry queue is full.
// each weight is inserted into the heap memory by a sift-up that reads the parent
// and then compares it at every level (single read port, registered data). the
// merge loop then takes n-1 merges, each two pops (read root, read last entry,
// sift down) and one insert; the walk reads one parent link per check and step
// pair of states up to the root for each code. results leave one beat per
// symbol in index order, each on valid_o for one cycle; the receiver cannot
// stall them. reset clears all control state and empties the block; heap and
// link memories need no clearing.
module huffman_code_builder #(
  parameter int unsigned SYMBOLS     = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [hcb_pkg::IN_WEIGHT_BITS-1:0]  weight_i,
  input  logic                                last_weight_i,
  output logic                                busy_o,
  output logic                                valid_o,
  output logic [hcb_pkg::OUT_SYM_BITS-1:0]    symbol_o,
  output logic [hcb_pkg::OUT_LEN_BITS-1:0]    code_length_o,
  output logic [hcb_pkg::OUT_CODE_BITS-1:0]   code_bits_o,
  output logic                                last_code_o
);

  hcb_pkg::q_stat_t     q_stat;
  logic                 q_push, q_pop, done;
  logic [WEIGHT_BITS:0] q_wdata, q_rdata;

  // input side
  hcb_front #(
    .SYMBOLS     (SYMBOLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .weight_i      (weight_i),
    .last_weight_i (last_weight_i),
    .q_stat_i      (q_stat),
    .done_i        (done),
    .busy_o        (busy_o),
    .push_o        (q_push),
    .push_data_o   (q_wdata)
  );

  // decoupling queue
  hcb_queue #(
    .DW (WEIGHT_BITS + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  // heap build and code walk
  hcb_engine #(
    .SYMBOLS     (SYMBOLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .done_o        (done),
    .valid_o       (valid_o),
    .symbol_o      (symbol_o),
    .code_length_o (code_length_o),
    .code_bits_o   (code_bits_o),
    .last_code_o   (last_code_o)
  );

endmodule
